/* hdl/mapc_pkg.sv */
// Shared types, codes and constants of the memory access pattern classifier.
package mapc_pkg;

  localparam int unsigned ADDR_WIDTH  = 64;
  localparam int unsigned LINE_SHIFT  = 6;
  localparam int unsigned COUNT_WIDTH = 48;
  localparam int unsigned TOTAL_WIDTH = 48;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_GRAN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    CLASS_WRITE     = 3'd0,
    CLASS_SAME_LINE = 3'd1,
    CLASS_STRIDED   = 3'd2,
    CLASS_CHASE     = 3'd3,
    CLASS_RANDOM    = 3'd4
  } class_e;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  function automatic count_t sat_inc(count_t cnt);
    return (cnt == '1) ? cnt : cnt + COUNT_WIDTH'(1);
  endfunction

endpackage

/* hdl/mapc_ifs.sv */
// Channel interfaces of the classifier: access stream, result stream and register writes.
interface mapc_access_if import mapc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [ADDR_WIDTH-1:0] addr;
  logic [ADDR_WIDTH-1:0] loaded_value;

  modport source (output valid, cmd, addr, loaded_value, input ready);
  modport sink   (input valid, cmd, addr, loaded_value, output ready);
endinterface

interface mapc_result_if import mapc_pkg::*;;
  logic                   valid;
  logic                   ready;
  class_e                 access_class;
  logic [TOTAL_WIDTH-1:0] read_total;
  logic [TOTAL_WIDTH-1:0] write_total;
  logic [TOTAL_WIDTH-1:0] same_line_total;
  logic [TOTAL_WIDTH-1:0] strided_total;
  logic [TOTAL_WIDTH-1:0] chase_total;
  logic [TOTAL_WIDTH-1:0] random_total;

  modport source (output valid, access_class, read_total, write_total, same_line_total,
                  strided_total, chase_total, random_total, input ready);
  modport sink   (input valid, access_class, read_total, write_total, same_line_total,
                  strided_total, chase_total, random_total, output ready);
endinterface

interface mapc_cfg_if import mapc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [ADDR_WIDTH-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

/* hdl/memory_access_pattern_classifier_unit.sv */
// Top level of the memory access pattern classifier.
//
//   channel  direction  beat contents
//   acc_i    in         cmd, addr, loaded_value
//   res_o    out        access_class and the six saturating totals
//   cfg_i    in         idx (0 line granularity, 1 base address), data
//
// One access per cycle sustained while results are taken; a result is offered once its beat
// has passed from the input register through the classify logic into the result register.
// The line number is formed when a beat enters the input register.
// Reset clears all registers but the input data fields; cfg_i is always ready.
// A stalled result holds the counters, and the input register takes one more beat.
module memory_access_pattern_classifier_unit import mapc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  mapc_access_if.sink   acc_i,
  mapc_result_if.source res_o,
  mapc_cfg_if.sink      cfg_i
);

  logic                  gran_q;
  logic [ADDR_WIDTH-1:0] base_q;

  logic                  s_valid_q;
  logic                  s_cmd_q;
  logic [ADDR_WIDTH-1:0] s_addr_q;
  logic [ADDR_WIDTH-1:0] s_word_q;
  logic [ADDR_WIDTH-1:0] s_line_q;

  logic                  r_valid_q;
  class_e                class_q, class_d;

  logic [ADDR_WIDTH-1:0] prev_addr_q, prev_line_q, prev_stride_q, prev_word_q;
  count_t reads_q, writes_q, same_q, strided_q, chase_q, random_q;

  logic adv, is_same, is_strided, is_chase;
  logic [ADDR_WIDTH-1:0] new_stride;

  assign cfg_i.ready = 1'b1;
  assign adv         = s_valid_q && (!r_valid_q || res_o.ready);
  assign acc_i.ready = !s_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gran_q <= 1'b0;
      base_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.idx)
        CFG_LINE_GRAN: gran_q <= cfg_i.data[0];
        CFG_BASE_ADDR: base_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (acc_i.ready) begin
      s_valid_q <= acc_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i.valid && acc_i.ready) begin
      s_cmd_q  <= acc_i.cmd;
      s_addr_q <= acc_i.addr;
      s_word_q <= acc_i.loaded_value;
      s_line_q <= (acc_i.addr - base_q) >> LINE_SHIFT;
    end
  end

  assign is_same    = s_line_q == prev_line_q;
  assign is_strided = gran_q ? ((prev_line_q + prev_stride_q) == s_line_q)
                             : ((prev_addr_q + prev_stride_q) == s_addr_q);
  assign is_chase   = s_addr_q == prev_word_q;
  assign new_stride = gran_q ? (s_line_q - prev_line_q) : (s_addr_q - prev_addr_q);

  always_comb begin
    if (s_cmd_q)         class_d = CLASS_WRITE;
    else if (is_same)    class_d = CLASS_SAME_LINE;
    else if (is_strided) class_d = CLASS_STRIDED;
    else if (is_chase)   class_d = CLASS_CHASE;
    else                 class_d = CLASS_RANDOM;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q     <= 1'b0;
      class_q       <= CLASS_WRITE;
      prev_addr_q   <= '0;
      prev_line_q   <= '0;
      prev_stride_q <= '0;
      prev_word_q   <= '0;
      reads_q       <= '0;
      writes_q      <= '0;
      same_q        <= '0;
      strided_q     <= '0;
      chase_q       <= '0;
      random_q      <= '0;
    end else begin
      if (adv) begin
        r_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        r_valid_q <= 1'b0;
      end
      if (adv) begin
        class_q <= class_d;
        if (s_cmd_q) begin
          writes_q <= sat_inc(writes_q);
        end else begin
          reads_q <= sat_inc(reads_q);
          if (is_same) begin
            same_q <= sat_inc(same_q);
          end else begin
            case (class_d)
              CLASS_STRIDED: strided_q <= sat_inc(strided_q);
              CLASS_CHASE:   chase_q   <= sat_inc(chase_q);
              default:       random_q  <= sat_inc(random_q);
            endcase
            prev_stride_q <= new_stride;
            prev_addr_q   <= s_addr_q;
            prev_line_q   <= s_line_q;
            prev_word_q   <= s_word_q;
          end
        end
      end
    end
  end

  assign res_o.valid           = r_valid_q;
  assign res_o.access_class    = class_q;
  assign res_o.read_total      = TOTAL_WIDTH'(reads_q);
  assign res_o.write_total     = TOTAL_WIDTH'(writes_q);
  assign res_o.same_line_total = TOTAL_WIDTH'(same_q);
  assign res_o.strided_total   = TOTAL_WIDTH'(strided_q);
  assign res_o.chase_total     = TOTAL_WIDTH'(chase_q);
  assign res_o.random_total    = TOTAL_WIDTH'(random_q);

`ifndef SYNTHESIS
  // A waiting result must keep the read, write and random totals it was written with.
  a_hold_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_valid_q && !res_o.ready) |=> ($stable(reads_q) && $stable(writes_q)
                                     && $stable(random_q)))
    else $error("totals changed under a stalled result");

  // A write leaves the read history untouched.
  a_write_keeps_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s_cmd_q) |=> ($stable(reads_q) && $stable(prev_line_q)))
    else $error("write disturbed read history");

  // A same-line read keeps the previous address and stride.
  a_same_line_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !s_cmd_q && is_same) |=> ($stable(prev_addr_q) && $stable(prev_stride_q)))
    else $error("same-line read updated history");

  // No beat is taken into a full input register that cannot drain.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_q && r_valid_q && !res_o.ready) |-> !acc_i.ready)
    else $error("input register overrun");
`endif

endmodule
